// File: sv/blli_pkg.sv
// Shared types, register indexes, reset values and codes for the battery LED indicator.
package blli_pkg;

    // Item kinds carried in the input tuser field.
    typedef enum logic [1:0] {
        OP_LEVEL  = 2'd0,
        OP_ACTIVE = 2'd1,
        OP_USB    = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_GOOD      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLANCE    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_INT  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_INT  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_OFF = 4'd7;

    localparam logic [6:0]  RST_GOOD      = 7'd80;
    localparam logic [6:0]  RST_LOW       = 7'd20;
    localparam logic [6:0]  RST_CRITICAL  = 7'd10;
    localparam logic [15:0] RST_GLANCE    = 16'd2000;
    localparam logic [23:0] RST_WARN_INT  = 24'd60000;
    localparam logic [23:0] RST_CRIT_INT  = 24'd30000;
    localparam logic [15:0] RST_BLINK_ON  = 16'd120;
    localparam logic [15:0] RST_BLINK_OFF = 16'd200;

    localparam int BLINKS_CRITICAL = 3;
    localparam int BLINKS_LOW      = 2;

    typedef struct packed {
        logic [6:0]  good_percent;
        logic [6:0]  low_percent;
        logic [6:0]  critical_percent;
        logic [15:0] glance_ticks;
        logic [23:0] warn_interval_ticks;
        logic [23:0] critical_interval_ticks;
        logic [15:0] blink_on_ticks;
        logic [15:0] blink_off_ticks;
    } t_cfg;

    typedef struct packed {
        t_op        opcode;
        logic [6:0] level;
        logic       active;
        logic       usb_present;
    } t_item;

    typedef struct packed {
        logic warning_armed;
        logic green_on;
        logic red_on;
    } t_result;

endpackage

// File: sv/blli_cfg.sv
// Configuration register file for the battery LED indicator.
module blli_cfg import blli_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.good_percent            <= RST_GOOD;
            r_cfg.low_percent             <= RST_LOW;
            r_cfg.critical_percent        <= RST_CRITICAL;
            r_cfg.glance_ticks            <= RST_GLANCE;
            r_cfg.warn_interval_ticks     <= RST_WARN_INT;
            r_cfg.critical_interval_ticks <= RST_CRIT_INT;
            r_cfg.blink_on_ticks          <= RST_BLINK_ON;
            r_cfg.blink_off_ticks         <= RST_BLINK_OFF;
        end else if (i_we) begin
            case (i_index)
                CFG_GOOD:      r_cfg.good_percent            <= i_data[6:0];
                CFG_LOW:       r_cfg.low_percent             <= i_data[6:0];
                CFG_CRITICAL:  r_cfg.critical_percent        <= i_data[6:0];
                CFG_GLANCE:    r_cfg.glance_ticks            <= i_data[15:0];
                CFG_WARN_INT:  r_cfg.warn_interval_ticks     <= i_data[23:0];
                CFG_CRIT_INT:  r_cfg.critical_interval_ticks <= i_data[23:0];
                CFG_BLINK_ON:  r_cfg.blink_on_ticks          <= i_data[15:0];
                CFG_BLINK_OFF: r_cfg.blink_off_ticks         <= i_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/blli_core.sv
// Indicator state registers and the next-state logic for one item.
module blli_core import blli_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    typedef struct packed {
        logic [6:0]  last_level;
        logic        level_known;
        logic        is_active;
        logic        on_usb;
        logic [2:0]  blink_steps;
        logic        lit_phase;
        logic [15:0] blink_timer;
        logic        blink_pend;
        logic [15:0] glance_timer;
        logic        glance_pend;
        logic [23:0] warn_timer;
        logic        warn_pend;
        logic        lamp_red;
        logic        lamp_green;
    } t_state;

    t_state r_state;
    t_state n_state;

    // Everything clears except the activity flag, which comes up active.
    function automatic t_state f_reset_state();
        t_state r;
        r = '0;
        r.is_active = 1'b1;
        return r;
    endfunction

    function automatic logic [15:0] f_load16(logic [15:0] t);
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

    function automatic logic [23:0] f_load24(logic [23:0] t);
        return (t == 24'd0) ? 24'd1 : t;
    endfunction

    function automatic t_state f_show_level(t_state s, t_cfg c);
        t_state r;
        r = s;
        if (s.last_level >= c.good_percent) begin
            r.lamp_red = 1'b0; r.lamp_green = 1'b1;
        end else if (s.last_level > c.low_percent) begin
            r.lamp_red = 1'b1; r.lamp_green = 1'b1;
        end else begin
            r.lamp_red = 1'b1; r.lamp_green = 1'b0;
        end
        return r;
    endfunction

    function automatic t_state f_rest(t_state s, t_cfg c);
        t_state r;
        r = s;
        if (s.level_known && s.on_usb) begin
            r = f_show_level(s, c);
        end else begin
            r.lamp_red = 1'b0; r.lamp_green = 1'b0;
        end
        return r;
    endfunction

    function automatic t_state f_blink_advance(t_state s, t_cfg c);
        t_state r;
        r = s;
        if (s.blink_steps == 3'd0) begin
            r = f_rest(s, c);
        end else begin
            r.lit_phase   = !s.lit_phase;
            r.lamp_red    = r.lit_phase;
            r.lamp_green  = 1'b0;
            r.blink_steps = s.blink_steps - 3'd1;
            r.blink_timer = r.lit_phase ? f_load16(c.blink_on_ticks)
                                        : f_load16(c.blink_off_ticks);
            r.blink_pend  = 1'b1;
        end
        return r;
    endfunction

    // Each blink is a lit phase and a dark phase, so the step count is twice the blinks.
    function automatic t_state f_blink_start(t_state s, t_cfg c, logic [6:0] lvl);
        t_state r;
        r = s;
        r.glance_pend = 1'b0;
        r.blink_steps = (lvl <= c.critical_percent) ? 3'(2 * BLINKS_CRITICAL)
                                                    : 3'(2 * BLINKS_LOW);
        r.lit_phase   = 1'b0;
        return f_blink_advance(r, c);
    endfunction

    function automatic t_state f_glance(t_state s, t_cfg c);
        t_state r;
        r = s;
        if (s.level_known) begin
            r.blink_pend   = 1'b0;
            r.blink_steps  = 3'd0;
            r              = f_show_level(r, c);
            r.glance_timer = f_load16(c.glance_ticks);
            r.glance_pend  = 1'b1;
        end
        return r;
    endfunction

    function automatic logic f_warn_needed(t_state s, t_cfg c);
        return s.level_known && (s.last_level <= c.low_percent) && !s.on_usb && s.is_active;
    endfunction

    function automatic logic [23:0] f_warn_interval(t_state s, t_cfg c);
        return (s.last_level <= c.critical_percent) ? f_load24(c.critical_interval_ticks)
                                                    : f_load24(c.warn_interval_ticks);
    endfunction

    function automatic t_state f_warn_update(t_state s, t_cfg c);
        t_state r;
        r = s;
        if (f_warn_needed(s, c)) begin
            if (!s.warn_pend) begin
                r.warn_timer = f_warn_interval(s, c);
                r.warn_pend  = 1'b1;
            end
        end else begin
            r.warn_pend = 1'b0;
        end
        return r;
    endfunction

    function automatic t_state f_step(t_state s, t_cfg c, t_item it);
        t_state r;
        logic   dropped;
        r = s;
        dropped = 1'b0;
        case (it.opcode)
            OP_LEVEL: begin
                dropped = ((s.last_level > c.low_percent) && (it.level <= c.low_percent)) ||
                          ((s.last_level > c.critical_percent) &&
                           (it.level <= c.critical_percent));
                r.last_level  = it.level;
                r.level_known = 1'b1;
                if (!s.level_known) begin
                    r = f_glance(r, c);
                end else if (dropped) begin
                    r = f_blink_start(r, c, it.level);
                end else if (r.blink_steps == 3'd0 && !r.glance_pend) begin
                    r = f_rest(r, c);
                end
                r = f_warn_update(r, c);
            end
            OP_ACTIVE: begin
                r.is_active = it.active;
                if (it.active) begin
                    r = f_glance(r, c);
                end else begin
                    r.blink_pend  = 1'b0;
                    r.glance_pend = 1'b0;
                    r.blink_steps = 3'd0;
                    r.lamp_red    = 1'b0;
                    r.lamp_green  = 1'b0;
                end
                r = f_warn_update(r, c);
            end
            OP_USB: begin
                r.on_usb = it.usb_present;
                if (r.blink_steps == 3'd0 && !r.glance_pend) begin
                    r = f_rest(r, c);
                end
                r = f_warn_update(r, c);
            end
            default: begin
                // All pending timers count down first; expiries then run blink, glance, warn.
                if (r.blink_pend && r.blink_timer != 16'd0) begin
                    r.blink_timer = r.blink_timer - 16'd1;
                end
                if (r.glance_pend && r.glance_timer != 16'd0) begin
                    r.glance_timer = r.glance_timer - 16'd1;
                end
                if (r.warn_pend && r.warn_timer != 24'd0) begin
                    r.warn_timer = r.warn_timer - 24'd1;
                end
                if (r.blink_pend && r.blink_timer == 16'd0) begin
                    r.blink_pend = 1'b0;
                    r = f_blink_advance(r, c);
                end
                if (r.glance_pend && r.glance_timer == 16'd0) begin
                    r.glance_pend = 1'b0;
                    r = f_rest(r, c);
                end
                if (r.warn_pend && r.warn_timer == 24'd0) begin
                    r.warn_pend = 1'b0;
                    if (f_warn_needed(r, c)) begin
                        r = f_blink_start(r, c, r.last_level);
                        r.warn_timer = f_warn_interval(r, c);
                        r.warn_pend  = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    always_comb begin
        n_state = f_step(r_state, i_cfg, i_item);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= f_reset_state();
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_result.red_on        = n_state.lamp_red;
    assign o_result.green_on      = n_state.lamp_green;
    assign o_result.warning_armed = n_state.warn_pend;

endmodule

// File: sv/battery_level_led_indicator.sv
// Top level of the battery LED indicator: input register, core and result register.
// One item is accepted in every cycle while tready is high. Each item passes an
// input register and a result register, and its result is offered once it has
// moved into the result register; a stalled result register holds the next item
// in the input register and drops tready only when both are full.
// Configuration writes are ready whenever reset is released and take effect on the
// next item; they belong between items once all results have been taken.
module battery_level_led_indicator import blli_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [15:0]           i_s_tdata,   // level[6:0], active[7], usb_present[8], zero
    input  logic [1:0]            i_s_tuser,   // opcode[1:0]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // red_on[0], green_on[1], warning_armed[2], zero
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_adv;
    logic    w_step;
    logic    w_accept;

    logic    r_in_v;
    t_item   r_item;
    logic    r_out_v;
    t_result r_result;

    assign w_adv      = !r_out_v || i_m_tready;
    assign w_step     = r_in_v && w_adv;
    assign o_s_tready = i_rst_n && (!r_in_v || w_adv);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_v <= 1'b1;
            end else if (w_adv) begin
                r_in_v <= 1'b0;
            end
            if (w_adv) begin
                r_out_v <= r_in_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.opcode      <= t_op'(i_s_tuser[1:0]);
            r_item.level       <= i_s_tdata[6:0];
            r_item.active      <= i_s_tdata[7];
            r_item.usb_present <= i_s_tdata[8];
        end
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_cfg_ready = i_rst_n;

    blli_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    blli_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {5'd0, r_result.warning_armed, r_result.green_on, r_result.red_on};

endmodule

// File: sv/blli_chk.sv
// Port-level checker for the battery LED indicator and its bind.
module blli_chk import blli_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [7:0]            o_m_tdata,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready
);

    // A waiting result stays offered and unchanged until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed or vanished while stalled");

    // Input backpressure only comes from a stalled result.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input not ready without an output stall");

    // A result is newly offered only when an item was accepted and has since passed the input register.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("result offered without a matching item");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind battery_level_led_indicator blli_chk u_blli_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

// File: bench/tb_battery_level_led_indicator.sv
// Self-checking bench for the battery LED indicator: directed and random items checked against a predictor.
module tb_battery_level_led_indicator;
    import blli_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 4'd15;   // index past the register list
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_AT      = 200;
    localparam int STALL_CYCLES  = 300;
    localparam int CALM_FROM     = 400;
    localparam int CALM_TO       = 480;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 80;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int PRINT_LIMIT   = 50;

    typedef enum {SET_ZERO, SET_MAX, SET_RANDOM} t_setting;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [15:0]           i_s_tdata = '0;     // level[6:0], active[7], usb_present[8], zero
    logic [1:0]            i_s_tuser = OP_TICK; // opcode[1:0]
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [7:0]            o_m_tdata;          // red_on[0], green_on[1], warning_armed[2], zero
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    battery_level_led_indicator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    t_item   items_to_send[$];
    t_item   item_on_bus = '0;
    t_result leds_expected[$];
    int      items_taken = 0;
    int      leds_seen = 0;
    int      mismatches = 0;
    int      settings_cnt = 0;
    int      walk_level = 100;
    logic    took_item = 1'b0;
    int      stall_left = 0;
    logic    stall_done = 1'b0;

    // Predictor state and its copy of the registers.
    t_cfg        cfg_now;
    logic [6:0]  lvl_last;
    logic        lvl_known, act, usb;
    logic [2:0]  blink_left;
    logic        lit_phase, blink_run, glance_run, warn_run;
    logic [15:0] blink_tmr, glance_tmr;
    logic [23:0] warn_tmr;
    logic        led_r, led_g;

    function automatic logic [23:0] at_least_one(input logic [23:0] t);
        return (t == '0) ? 24'd1 : t;
    endfunction

    function automatic void show_color();
        if (lvl_last >= cfg_now.good_percent) begin
            led_r = 1'b0; led_g = 1'b1;
        end else if (lvl_last > cfg_now.low_percent) begin
            led_r = 1'b1; led_g = 1'b1;
        end else begin
            led_r = 1'b1; led_g = 1'b0;
        end
    endfunction

    function automatic void show_dark();
        led_r = 1'b0;
        led_g = 1'b0;
    endfunction

    function automatic void settle();
        if (lvl_known && usb) show_color();
        else show_dark();
    endfunction

    function automatic void blink_next();
        if (blink_left == 0) begin
            settle();
            return;
        end
        lit_phase = !lit_phase;
        if (lit_phase) begin
            led_r = 1'b1; led_g = 1'b0;
        end else begin
            show_dark();
        end
        blink_left = blink_left - 3'd1;
        blink_tmr = 16'(at_least_one(24'(lit_phase ? cfg_now.blink_on_ticks
                                                   : cfg_now.blink_off_ticks)));
        blink_run = 1'b1;
    endfunction

    function automatic void blink_begin(input int times);
        glance_run = 1'b0;
        blink_left = 3'(times * 2);
        lit_phase = 1'b0;
        blink_next();
    endfunction

    function automatic void glance_begin();
        if (!lvl_known) return;
        blink_run = 1'b0;
        blink_left = '0;
        show_color();
        glance_tmr = 16'(at_least_one(24'(cfg_now.glance_ticks)));
        glance_run = 1'b1;
    endfunction

    function automatic logic warn_due();
        return lvl_known && lvl_last <= cfg_now.low_percent && !usb && act;
    endfunction

    function automatic logic [23:0] warn_period();
        return at_least_one(lvl_last <= cfg_now.critical_percent ?
                            cfg_now.critical_interval_ticks : cfg_now.warn_interval_ticks);
    endfunction

    function automatic int blink_times(input logic [6:0] lvl);
        return (lvl <= cfg_now.critical_percent) ? BLINKS_CRITICAL : BLINKS_LOW;
    endfunction

    function automatic void warn_refresh();
        if (warn_due()) begin
            if (!warn_run) begin
                warn_tmr = warn_period();
                warn_run = 1'b1;
            end
        end else begin
            warn_run = 1'b0;
        end
    endfunction

    function automatic logic fell_past(input logic [6:0] prev, input logic [6:0] cur);
        return (prev > cfg_now.low_percent && cur <= cfg_now.low_percent) ||
               (prev > cfg_now.critical_percent && cur <= cfg_now.critical_percent);
    endfunction

    function automatic void level_event(input logic [6:0] lvl);
        logic       first;
        logic [6:0] prev;
        first = !lvl_known;
        prev = lvl_last;
        lvl_last = lvl;
        lvl_known = 1'b1;
        if (first) glance_begin();
        else if (fell_past(prev, lvl)) blink_begin(blink_times(lvl));
        else if (blink_left == 0 && !glance_run) settle();
        warn_refresh();
    endfunction

    // All running timers count down before any expiry is handled.
    function automatic void tick_event();
        if (blink_run && blink_tmr != 0) blink_tmr = blink_tmr - 16'd1;
        if (glance_run && glance_tmr != 0) glance_tmr = glance_tmr - 16'd1;
        if (warn_run && warn_tmr != 0) warn_tmr = warn_tmr - 24'd1;
        if (blink_run && blink_tmr == 0) begin
            blink_run = 1'b0;
            blink_next();
        end
        if (glance_run && glance_tmr == 0) begin
            glance_run = 1'b0;
            settle();
        end
        if (warn_run && warn_tmr == 0) begin
            warn_run = 1'b0;
            if (warn_due()) begin
                blink_begin(blink_times(lvl_last));
                warn_tmr = warn_period();
                warn_run = 1'b1;
            end
        end
    endfunction

    function automatic t_result model_step(input t_item it);
        t_result res;
        case (it.opcode)
            OP_LEVEL: level_event(it.level);
            OP_ACTIVE: begin
                act = it.active;
                if (act) begin
                    glance_begin();
                end else begin
                    blink_run = 1'b0;
                    glance_run = 1'b0;
                    blink_left = '0;
                    show_dark();
                end
                warn_refresh();
            end
            OP_USB: begin
                usb = it.usb_present;
                if (blink_left == 0 && !glance_run) settle();
                warn_refresh();
            end
            default: tick_event();
        endcase
        res.red_on = led_r;
        res.green_on = led_g;
        res.warning_armed = warn_run;
        return res;
    endfunction

    function automatic void model_reset();
        cfg_now.good_percent = RST_GOOD;
        cfg_now.low_percent = RST_LOW;
        cfg_now.critical_percent = RST_CRITICAL;
        cfg_now.glance_ticks = RST_GLANCE;
        cfg_now.warn_interval_ticks = RST_WARN_INT;
        cfg_now.critical_interval_ticks = RST_CRIT_INT;
        cfg_now.blink_on_ticks = RST_BLINK_ON;
        cfg_now.blink_off_ticks = RST_BLINK_OFF;
        lvl_last = '0; lvl_known = 1'b0; act = 1'b1; usb = 1'b0;
        blink_left = '0; lit_phase = 1'b0;
        blink_tmr = '0; glance_tmr = '0; warn_tmr = '0;
        blink_run = 1'b0; glance_run = 1'b0; warn_run = 1'b0;
        led_r = 1'b0; led_g = 1'b0;
    endfunction

    function automatic void model_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_GOOD:      cfg_now.good_percent = val[6:0];
            CFG_LOW:       cfg_now.low_percent = val[6:0];
            CFG_CRITICAL:  cfg_now.critical_percent = val[6:0];
            CFG_GLANCE:    cfg_now.glance_ticks = val[15:0];
            CFG_WARN_INT:  cfg_now.warn_interval_ticks = val;
            CFG_CRIT_INT:  cfg_now.critical_interval_ticks = val;
            CFG_BLINK_ON:  cfg_now.blink_on_ticks = val[15:0];
            CFG_BLINK_OFF: cfg_now.blink_off_ticks = val[15:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) $display("MISMATCH: %s", msg);
    endtask

    // Handshakes are sampled here; the predictor runs in this process only.
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        took_item = 1'b0;
        if (!i_rst_n) begin
            model_reset();
        end else begin
            if (i_cfg_valid && o_cfg_ready) model_write(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && o_s_tready) begin
                leds_expected.push_back(model_step(item_on_bus));
                items_taken++;
                took_item = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                got = t_result'(o_m_tdata[2:0]);
                leds_seen++;
                if (leds_expected.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              leds_seen));
                end else begin
                    want = leds_expected.pop_front();
                    if (got.red_on !== want.red_on)
                        report_mismatch($sformatf("result %0d red_on %b, expected %b",
                                                  leds_seen, got.red_on, want.red_on));
                    if (got.green_on !== want.green_on)
                        report_mismatch($sformatf("result %0d green_on %b, expected %b",
                                                  leds_seen, got.green_on, want.green_on));
                    if (got.warning_armed !== want.warning_armed)
                        report_mismatch($sformatf("result %0d warning_armed %b, expected %b",
                                                  leds_seen, got.warning_armed,
                                                  want.warning_armed));
                end
            end
        end
    end

    // An offered item stays on the bus until it is taken.
    always @(negedge i_clk) begin : sender
        if (i_rst_n && (!i_s_tvalid || took_item)) begin
            if (items_to_send.size() != 0 &&
                ((items_taken >= CALM_FROM && items_taken < CALM_TO) ||
                 $urandom_range(0, 99) >= 20)) begin
                item_on_bus = items_to_send.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser <= item_on_bus.opcode;
                i_s_tdata <= {7'd0, item_on_bus.usb_present, item_on_bus.active,
                              item_on_bus.level};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Once, the receiver holds off long enough for the block to fill and stall its input.
    always @(negedge i_clk) begin : receiver
        if (!stall_done && leds_seen >= STALL_AT) begin
            stall_left = STALL_CYCLES;
            stall_done = 1'b1;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (leds_seen >= CALM_FROM && leds_seen < CALM_TO) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= 20);
        end
    end

    task automatic queue_item(input t_op op, input logic [6:0] lvl, input logic a,
                              input logic u);
        t_item it;
        it.opcode = op;
        it.level = lvl;
        it.active = a;
        it.usb_present = u;
        items_to_send.push_back(it);
    endtask

    // Levels mostly drift downward so that threshold crossings happen often.
    task automatic queue_random_item();
        int         r;
        logic [6:0] noise_lvl;
        r = $urandom_range(0, 99);
        noise_lvl = 7'($urandom_range(0, 127));
        if (r < 55) begin
            queue_item(OP_TICK, noise_lvl, 1'($urandom), 1'($urandom));
        end else if (r < 75) begin
            if ($urandom_range(0, 9) < 7) begin
                walk_level = walk_level - int'($urandom_range(0, 6));
                if (walk_level < 0) walk_level = $urandom_range(30, 127);
            end else begin
                walk_level = $urandom_range(0, 127);
            end
            queue_item(OP_LEVEL, 7'(walk_level), 1'($urandom), 1'($urandom));
        end else if (r < 85) begin
            queue_item(OP_USB, noise_lvl, 1'($urandom), 1'($urandom));
        end else begin
            queue_item(OP_ACTIVE, noise_lvl, ($urandom_range(0, 3) != 0), 1'($urandom));
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic cfg_release();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_cnt++;
    endtask

    task automatic wait_drained();
        while (items_to_send.size() != 0 || i_s_tvalid || leds_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Upper data bits above a register's width carry noise that the block must drop.
    task automatic program_setting(input t_setting kind);
        int          good, low, crit, glance, warn, crit_int, on_t, off_t;
        logic [31:0] noise;
        if (kind == SET_ZERO) begin
            good = 0; low = 0; crit = 0; glance = 0; warn = 0; crit_int = 0; on_t = 0; off_t = 0;
            noise = '0;
        end else if (kind == SET_MAX) begin
            good = 127; low = 127; crit = 127; glance = 65535; warn = 24'hFFFFFF;
            crit_int = 24'hFFFFFF; on_t = 65535; off_t = 65535;
            noise = '1;
        end else begin
            if ($urandom_range(0, 3) != 0) begin
                crit = $urandom_range(0, 40);
                low = crit + $urandom_range(0, 30);
                good = low + $urandom_range(1, 40);
                if (good > 127) good = 127;
            end else begin
                crit = $urandom_range(0, 127);
                low = $urandom_range(0, 127);
                good = $urandom_range(0, 127);
            end
            glance = $urandom_range(0, 12);
            warn = $urandom_range(0, 40);
            crit_int = $urandom_range(0, 25);
            on_t = $urandom_range(0, 4);
            off_t = $urandom_range(0, 4);
            noise = $urandom;
        end
        cfg_write(CFG_GOOD, 24'((noise << 7) | good));
        cfg_write(CFG_LOW, 24'((noise << 7) | low));
        cfg_write(CFG_CRITICAL, 24'((noise << 7) | crit));
        cfg_write(CFG_GLANCE, 24'((noise << 16) | glance));
        cfg_write(CFG_WARN_INT, 24'(warn));
        cfg_write(CFG_CRIT_INT, 24'(crit_int));
        cfg_write(CFG_BLINK_ON, 24'((noise << 16) | on_t));
        cfg_write(CFG_BLINK_OFF, 24'((noise << 16) | off_t));
        if (kind == SET_RANDOM && $urandom_range(0, 3) == 0) cfg_write(CFG_NONE, 24'($urandom));
        cfg_release();
    endtask

    initial begin : stimulus
        int       p;
        t_setting kind;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        settings_cnt = 1;

        // Reset settings: first level, drops past low and critical, activity, USB, level above 100.
        queue_item(OP_TICK, 7'd0, 1'b0, 1'b0);
        queue_item(OP_USB, 7'd127, 1'b0, 1'b1);
        queue_item(OP_LEVEL, 7'd90, 1'b1, 1'b0);
        queue_item(OP_LEVEL, 7'd15, 1'b0, 1'b1);
        queue_item(OP_TICK, 7'd127, 1'b1, 1'b1);
        queue_item(OP_ACTIVE, 7'd5, 1'b0, 1'b1);
        queue_item(OP_ACTIVE, 7'd0, 1'b1, 1'b0);
        queue_item(OP_USB, 7'd100, 1'b1, 1'b0);
        queue_item(OP_LEVEL, 7'd5, 1'b0, 1'b0);
        queue_item(OP_LEVEL, 7'd127, 1'b1, 1'b1);
        queue_item(OP_LEVEL, 7'd0, 1'b0, 1'b0);
        wait_drained();

        // Short timers, with zero blink-on time acting as one tick.
        cfg_write(CFG_GOOD, 24'd60);
        cfg_write(CFG_LOW, 24'd30);
        cfg_write(CFG_CRITICAL, 24'd15);
        cfg_write(CFG_GLANCE, 24'd2);
        cfg_write(CFG_WARN_INT, 24'd6);
        cfg_write(CFG_CRIT_INT, 24'd4);
        cfg_write(CFG_BLINK_ON, 24'd0);
        cfg_write(CFG_BLINK_OFF, 24'd1);
        cfg_write(CFG_NONE, 24'hFFFFFF);
        cfg_release();
        queue_item(OP_LEVEL, 7'd100, 1'b0, 1'b0);
        repeat (3) queue_item(OP_TICK, 7'd0, 1'b0, 1'b0);
        queue_item(OP_LEVEL, 7'd25, 1'b0, 1'b0);
        repeat (5) queue_item(OP_TICK, 7'd0, 1'b0, 1'b0);
        queue_item(OP_LEVEL, 7'd12, 1'b0, 1'b0);
        queue_item(OP_USB, 7'd0, 1'b0, 1'b1);
        queue_item(OP_TICK, 7'd0, 1'b0, 1'b0);
        queue_item(OP_ACTIVE, 7'd0, 1'b0, 1'b0);
        queue_item(OP_ACTIVE, 7'd0, 1'b1, 1'b0);
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            if (p == 0) kind = SET_ZERO;
            else if (p == PHASES - 2) kind = SET_MAX;
            else kind = SET_RANDOM;
            program_setting(kind);
            repeat (PHASE_ITEMS) queue_random_item();
            wait_drained();
        end

        $display("Checked %0d results from %0d items over %0d register settings,", leds_seen,
                 items_taken, settings_cnt);
        $display("including all-zero and all-max settings and a %0d-cycle output stall.",
                 STALL_CYCLES);
        if (mismatches == 0 && leds_expected.size() == 0) begin
            $display("battery_level_led_indicator test passed");
        end else begin
            $display("battery_level_led_indicator test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(2 * HALF_PERIOD * LIMIT_CYCLES);
        $display("Timeout with %0d results still expected.", leds_expected.size());
        $display("battery_level_led_indicator test failed");
        $finish;
    end

endmodule

// File: files.f
sv/blli_pkg.sv
sv/blli_cfg.sv
sv/blli_core.sv
sv/battery_level_led_indicator.sv
sv/blli_chk.sv
bench/tb_battery_level_led_indicator.sv
